// File: rtl/jetp_pkg.sv
package jetp_pkg;

  localparam int COORD_W    = 32;
  localparam int PROD_W     = 64;
  localparam int ITER_W     = 16;
  localparam int HUE_W      = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int OUT_TDATA_W = ITER_W + HUE_W;

  // Register map of the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_X_START  = 3'd0,
    REG_Y_START  = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_C_REAL   = 3'd4,
    REG_C_IMAG   = 3'd5,
    REG_MAX_ITER = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_start;
    logic signed [COORD_W-1:0] y_start;
    logic signed [COORD_W-1:0] x_step;
    logic signed [COORD_W-1:0] y_step;
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;
    logic [ITER_W-1:0]         max_iter;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_MUL,
    ST_START_ADD,
    ST_ITER_MUL,
    ST_ITER_UPD,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture pixel indices, clear count and escape flag
    logic mul_iter;   // multiplier operands: 1 = z terms, 0 = start terms
    logic start_set;  // load z from the start point sums
    logic update;     // load z from the squaring step, bump the count
    logic set_esc;    // mark the pixel as escaped
    logic emit;       // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_sat;   // start point left the 32-bit range
    logic outside;     // |z|^2 is above the bailout radius
    logic upd_sat;     // the squaring step saturated
    logic last;        // this update reaches the iteration limit
    logic zero_limit;  // max_iter is zero
    logic out_free;    // output register can take a word this cycle
  } status_t;

endpackage

// File: rtl/julia_escape_time_pixel.sv
// Julia-set escape-time engine for one pixel per input word. The input word
// carries a column and a row; the start point is z = (x_start + column*x_step,
// y_start + row*y_step), and the block iterates z = z^2 + c while |z|^2 <= 4
// and the count is below max_iter. The output word carries the iteration
// count and a hue byte (count modulo 256 when the point escaped, else zero);
// tuser carries the escaped flag. Coordinates are signed fixed point with
// FRACTION_BITS fractional bits (Q6.26 by default). The bailout test is exact
// on the full 64-bit sum of squares; new parts are floored and saturated to
// 32 bits, and any saturation, of the start point or of an update, ends the
// pixel as escaped (a saturated start reports zero iterations, a saturated
// update is still counted). Columns and rows wrap at MAX_COLUMNS and
// MAX_ROWS. One pixel is in work at a time. Each pixel passes a start multiply and
// a start add; unless the start saturates or the limit is zero, it then loops
// through the shared bank of three 32x32 multipliers and the add, compare and
// saturate stage once per update until the bailout test, a saturation or the
// limit stops it. A result sits in an output register, so the next pixel is
// taken while it waits.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata; the user
// must write it only while the block is idle, as the block itself does not
// enforce this. Unknown register indexes are ignored.
module julia_escape_time_pixel #(
  parameter int MAX_COLUMNS   = 4096,
  parameter int MAX_ROWS      = 4096,
  parameter int FRACTION_BITS = 26
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration write port.
  input  logic                                   cfg_we,
  input  logic [jetp_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [jetp_pkg::COORD_W-1:0]           cfg_wdata,
  // Pixel input stream.
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // From bit 0 up: column, row, zero fill to whole bytes.
  input  logic [(($clog2(MAX_COLUMNS) + $clog2(MAX_ROWS) + 7) / 8) * 8 - 1:0] s_tdata,
  // Result output stream.
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // From bit 0 up: iterations (16 bits), hue (8 bits).
  output logic [jetp_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // Escaped flag.
  output logic                                   m_tuser
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  jetp_pkg::cfg_t     cfg;
  jetp_pkg::cmd_t     cmd;
  jetp_pkg::status_t  status;

  logic [jetp_pkg::ITER_W-1:0] iterations;
  logic                        escaped;
  logic [jetp_pkg::HUE_W-1:0]  hue;

  // Configuration registers. The reset view starts at -2 - 1i with a step of
  // about 0.005, with the seed c = -0.4 + 0.6i and a limit of 10000 iterations.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_start  <= -32'sd134217728;
      cfg.y_start  <= -32'sd67108864;
      cfg.x_step   <= 32'sd335544;
      cfg.y_step   <= 32'sd335544;
      cfg.c_real   <= -32'sd26843546;
      cfg.c_imag   <= 32'sd40265318;
      cfg.max_iter <= 16'd10000;
    end else if (cfg_we) begin
      unique case (jetp_pkg::reg_index_t'(cfg_addr))
        jetp_pkg::REG_X_START:  cfg.x_start  <= cfg_wdata;
        jetp_pkg::REG_Y_START:  cfg.y_start  <= cfg_wdata;
        jetp_pkg::REG_X_STEP:   cfg.x_step   <= cfg_wdata;
        jetp_pkg::REG_Y_STEP:   cfg.y_step   <= cfg_wdata;
        jetp_pkg::REG_C_REAL:   cfg.c_real   <= cfg_wdata;
        jetp_pkg::REG_C_IMAG:   cfg.c_imag   <= cfg_wdata;
        jetp_pkg::REG_MAX_ITER: cfg.max_iter <= cfg_wdata[jetp_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // The controller sequences start point, iterations and hand-off; the
  // datapath holds z, the multiplier bank, the count and the output word.
  jetp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  jetp_dp #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROWS      (MAX_ROWS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .column     (s_tdata[COL_W-1:0]),
    .row        (s_tdata[COL_W+ROW_W-1:COL_W]),
    .cmd        (cmd),
    .status     (status),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .iterations (iterations),
    .escaped    (escaped),
    .hue        (hue)
  );

  assign m_tdata = {hue, iterations};
  assign m_tuser = escaped;

endmodule

// File: rtl/jetp_ctrl.sv
module jetp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output jetp_pkg::cmd_t     cmd,
  input  jetp_pkg::status_t  status
);

  jetp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jetp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      jetp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = jetp_pkg::ST_START_MUL;
        end
      end
      jetp_pkg::ST_START_MUL: begin
        state_next = jetp_pkg::ST_START_ADD;
      end
      jetp_pkg::ST_START_ADD: begin
        cmd.start_set = 1'b1;
        if (status.start_sat) begin
          cmd.set_esc = 1'b1;
          state_next  = jetp_pkg::ST_FINISH;
        end else if (status.zero_limit) begin
          state_next = jetp_pkg::ST_FINISH;
        end else begin
          state_next = jetp_pkg::ST_ITER_MUL;
        end
      end
      jetp_pkg::ST_ITER_MUL: begin
        cmd.mul_iter = 1'b1;
        state_next   = jetp_pkg::ST_ITER_UPD;
      end
      jetp_pkg::ST_ITER_UPD: begin
        // The bailout test comes before the update; a saturating update
        // still counts and then ends the pixel as escaped.
        if (status.outside) begin
          cmd.set_esc = 1'b1;
          state_next  = jetp_pkg::ST_FINISH;
        end else begin
          cmd.update = 1'b1;
          if (status.upd_sat) begin
            cmd.set_esc = 1'b1;
            state_next  = jetp_pkg::ST_FINISH;
          end else if (status.last) begin
            state_next = jetp_pkg::ST_FINISH;
          end else begin
            state_next = jetp_pkg::ST_ITER_MUL;
          end
        end
      end
      jetp_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = jetp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = jetp_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result emitted while the output register is occupied");

  a_mul_then_upd: assert property (@(posedge clk) disable iff (rst)
    state == jetp_pkg::ST_ITER_MUL |=> state == jetp_pkg::ST_ITER_UPD)
    else $error("multiply stage not followed by update stage");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == jetp_pkg::ST_START_MUL)
    else $error("accepted word did not start the start-point multiply");
`endif

endmodule

// File: rtl/jetp_dp.sv
module jetp_dp #(
  parameter int MAX_COLUMNS   = 4096,
  parameter int MAX_ROWS      = 4096,
  parameter int FRACTION_BITS = 26
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  jetp_pkg::cfg_t                         cfg,
  input  logic [$clog2(MAX_COLUMNS)-1:0]         column,
  input  logic [$clog2(MAX_ROWS)-1:0]            row,
  input  jetp_pkg::cmd_t                         cmd,
  output jetp_pkg::status_t                      status,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [jetp_pkg::ITER_W-1:0]            iterations,
  output logic                                   escaped,
  output logic [jetp_pkg::HUE_W-1:0]             hue
);

  localparam int COL_W    = $clog2(MAX_COLUMNS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CW       = jetp_pkg::COORD_W;
  localparam int PW       = jetp_pkg::PROD_W;
  localparam int IW       = jetp_pkg::ITER_W;
  localparam int BAIL_SH  = 2 * FRACTION_BITS + 2;
  // 4 in the squared format; when it does not fit, every point is inside.
  localparam logic [PW-1:0] BAIL_LIM = (BAIL_SH > PW - 1) ? {PW{1'b1}}
                                                           : (PW'(1) << BAIL_SH);

  function automatic logic [CW:0] sat32(input logic signed [PW-1:0] v);
    logic in_range;
    in_range = (&v[PW-1:CW-1]) || (~|v[PW-1:CW-1]);
    if (in_range) begin
      return {1'b0, v[CW-1:0]};
    end
    return {1'b1, v[PW-1], {(CW-1){~v[PW-1]}}};
  endfunction

  logic [COL_W-1:0]        col_q, col_mod;
  logic [ROW_W-1:0]        row_q, row_mod;
  logic signed [CW-1:0]    x, y;
  logic signed [CW-1:0]    a0, b0, a1, b1;
  logic signed [PW-1:0]    p0, p1, p2;
  logic signed [PW-1:0]    sx, sy, diff, re_wide, im_wide;
  logic [PW-1:0]           mag;
  logic [CW:0]             sx_s, sy_s, re_s, im_s;
  logic [IW-1:0]           count;
  logic                    esc;

  // Indices beyond the image wrap; a wider field is below twice the size.
  assign col_mod = ({1'b0, column} >= (COL_W + 1)'(MAX_COLUMNS))
                   ? column - COL_W'(MAX_COLUMNS) : column;
  assign row_mod = ({1'b0, row} >= (ROW_W + 1)'(MAX_ROWS))
                   ? row - ROW_W'(MAX_ROWS) : row;

  // Shared multiplier bank: start terms first, then x*x, y*y and x*y.
  assign a0 = cmd.mul_iter ? x : $signed(CW'(col_q));
  assign b0 = cmd.mul_iter ? x : cfg.x_step;
  assign a1 = cmd.mul_iter ? y : $signed(CW'(row_q));
  assign b1 = cmd.mul_iter ? y : cfg.y_step;

  // Operands are sign extended, so each product is a signed 32x32 multiply.
  always_ff @(posedge clk) begin
    p0 <= PW'(a0) * PW'(b0);
    p1 <= PW'(a1) * PW'(b1);
    p2 <= PW'(x) * PW'(y);
  end

  assign sx   = PW'($signed(cfg.x_start)) + p0;
  assign sy   = PW'($signed(cfg.y_start)) + p1;
  assign sx_s = sat32(sx);
  assign sy_s = sat32(sy);

  assign mag     = p0 + p1;
  assign diff    = p0 - p1;
  assign re_wide = (diff >>> FRACTION_BITS) + PW'($signed(cfg.c_real));
  assign im_wide = (p2 >>> (FRACTION_BITS - 1)) + PW'($signed(cfg.c_imag));
  assign re_s    = sat32(re_wide);
  assign im_s    = sat32(im_wide);

  assign status.start_sat  = sx_s[CW] | sy_s[CW];
  assign status.outside    = mag > BAIL_LIM;
  assign status.upd_sat    = re_s[CW] | im_s[CW];
  assign status.last       = ((IW + 1)'(count) + (IW + 1)'(1)) >= (IW + 1)'(cfg.max_iter);
  assign status.zero_limit = (cfg.max_iter == '0);
  assign status.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q <= col_mod;
      row_q <= row_mod;
      count <= '0;
      esc   <= 1'b0;
    end else begin
      if (cmd.update) begin
        count <= count + IW'(1);
      end
      if (cmd.set_esc) begin
        esc <= 1'b1;
      end
    end
    if (cmd.start_set) begin
      x <= sx_s[CW-1:0];
      y <= sy_s[CW-1:0];
    end else if (cmd.update) begin
      x <= re_s[CW-1:0];
      y <= im_s[CW-1:0];
    end
    if (cmd.emit) begin
      iterations <= count;
      escaped    <= esc;
      hue        <= esc ? count[jetp_pkg::HUE_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("emitted result not presented");

  a_sat_escapes: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && status.upd_sat) |-> cmd.set_esc)
    else $error("saturated update did not mark escape");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (count == '0 && !esc))
    else $error("new pixel did not clear count and escape flag");
`endif

endmodule

// File: tb/julia_escape_time_pixel_tb.sv
module julia_escape_time_pixel_tb;

  localparam int MAX_COLUMNS   = 4096;
  localparam int MAX_ROWS      = 4096;
  localparam int FRACTION_BITS = 26;
  localparam int COL_W         = $clog2(MAX_COLUMNS);
  localparam int ROW_W         = $clog2(MAX_ROWS);
  localparam int PIX_W         = ((COL_W + ROW_W + 7) / 8) * 8;

  // Index 7 is not a register; the block must leave everything alone.
  localparam logic [jetp_pkg::CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

  // Longest wait for the outstanding words: enough for a pixel at the widest
  // limit, plus margin for the stalls of the result side.
  localparam int DRAIN_LIMIT = 2 * 65535 + 4000;
  // Cycles left to pass once the last word is in, before any register write.
  localparam int SETTLE      = 8;

  // |z|^2 <= 4 in the squared format, which carries twice the fraction bits.
  localparam longint unsigned BAILOUT = 64'd1 << (2 * FRACTION_BITS + 2);

  typedef struct {
    logic [jetp_pkg::ITER_W-1:0] iterations;
    logic                        escaped;
    logic [jetp_pkg::HUE_W-1:0]  hue;
  } pixel_word_t;

  // Keeps its own copy of the registers, works out the escape-time word of
  // every pixel the block takes, and matches the words that come back in
  // order against those.
  class julia_pixel_checker;
    logic signed [jetp_pkg::COORD_W-1:0] x_start, y_start, x_step, y_step, c_real, c_imag;
    logic [jetp_pkg::ITER_W-1:0]         max_iter;
    pixel_word_t                         awaited[$];
    int                                  errors;
    int                                  checked;
    int                                  deepest;

    function new();
      x_start  = -134217728;
      y_start  = -67108864;
      x_step   = 335544;
      y_step   = 335544;
      c_real   = -26843546;
      c_imag   = 40265318;
      max_iter = 10000;
      errors   = 0;
      checked  = 0;
      deepest  = 0;
    endfunction

    function void write_reg(logic [jetp_pkg::CFG_ADDR_W-1:0] idx,
                            logic [jetp_pkg::COORD_W-1:0] value);
      case (idx)
        jetp_pkg::REG_X_START:  x_start  = value;
        jetp_pkg::REG_Y_START:  y_start  = value;
        jetp_pkg::REG_X_STEP:   x_step   = value;
        jetp_pkg::REG_Y_STEP:   y_step   = value;
        jetp_pkg::REG_C_REAL:   c_real   = value;
        jetp_pkg::REG_C_IMAG:   c_imag   = value;
        jetp_pkg::REG_MAX_ITER: max_iter = value[jetp_pkg::ITER_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp to the signed 32-bit range and raise the flag when clamping bites.
    function longint clamp32(longint v, inout bit hit);
      if (v > 64'sd2147483647) begin
        hit = 1'b1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        hit = 1'b1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function pixel_word_t escape_time(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      longint          x, y, nx, ny, cr, ci;
      longint unsigned mag;
      bit              sat;
      bit              esc;
      int              count;
      pixel_word_t     w;
      sat   = 1'b0;
      esc   = 1'b0;
      count = 0;
      cr    = longint'(c_real);
      ci    = longint'(c_imag);
      x = clamp32(longint'(x_start) + longint'(col) * longint'(x_step), sat);
      y = clamp32(longint'(y_start) + longint'(row) * longint'(y_step), sat);
      if (sat) begin
        // A start point off the coordinate range escapes before any update.
        esc = 1'b1;
      end else begin
        while (count < max_iter) begin
          mag = $unsigned(x * x) + $unsigned(y * y);
          if (mag > BAILOUT) begin
            esc = 1'b1;
            break;
          end
          nx = clamp32(((x * x - y * y) >>> FRACTION_BITS) + cr, sat);
          ny = clamp32(((x * y) >>> (FRACTION_BITS - 1)) + ci, sat);
          x = nx;
          y = ny;
          count++;
          // The saturating update still counts, even when it hits the limit.
          if (sat) begin
            esc = 1'b1;
            break;
          end
        end
      end
      w.iterations = count[jetp_pkg::ITER_W-1:0];
      w.escaped    = esc;
      w.hue        = esc ? count[jetp_pkg::HUE_W-1:0] : '0;
      return w;
    endfunction

    function void take_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      pixel_word_t w;
      w = escape_time(col, row);
      if (w.iterations > deepest) deepest = w.iterations;
      awaited.push_back(w);
    endfunction

    function void check_pixel_word(logic [jetp_pkg::ITER_W-1:0] iterations,
                                   logic [jetp_pkg::HUE_W-1:0] hue,
                                   logic escaped);
      pixel_word_t w;
      if (awaited.size() == 0) begin
        $display("%0t: result word with no pixel outstanding: iterations %0d hue %0d",
                 $time, iterations, hue);
        $display("%0t: escaped %0b", $time, escaped);
        errors++;
        return;
      end
      w = awaited.pop_front();
      checked++;
      if (iterations !== w.iterations) begin
        $display("%0t: iterations expected %0d got %0d", $time, w.iterations, iterations);
        errors++;
      end
      if (escaped !== w.escaped) begin
        $display("%0t: escaped expected %0b got %0b", $time, w.escaped, escaped);
        errors++;
      end
      if (hue !== w.hue) begin
        $display("%0t: hue expected %0d got %0d", $time, w.hue, hue);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [jetp_pkg::CFG_ADDR_W-1:0]  cfg_addr;
  logic [jetp_pkg::COORD_W-1:0]     cfg_wdata;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [PIX_W-1:0]                 s_tdata;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [jetp_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tuser;

  // When set, neither side inserts gaps, so the block runs back to back.
  bit steady = 1'b0;
  int views  = 1;

  julia_pixel_checker book = new();

  julia_escape_time_pixel #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROWS     (MAX_ROWS),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length for either side: half the time none, otherwise mostly a short
  // one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // The result side drops tready for random stretches. Changes land on the
  // falling edge, at most once per edge.
  initial begin : result_stalls
    int run;
    int gap;
    forever begin
      m_tready <= 1'b1;
      run = $urandom_range(1, 20);
      repeat (run) @(negedge clk);
      if (!steady) begin
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // Every result word the block hands over is checked on the edge it moves.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      book.check_pixel_word(m_tdata[jetp_pkg::ITER_W-1:0],
                            m_tdata[jetp_pkg::ITER_W +: jetp_pkg::HUE_W], m_tuser);
  end

  // Called on a falling edge while the block is idle. The enable is raised for
  // a single cycle, and the task returns only after it is lowered, so
  // back-to-back calls never raise and lower it within the same step.
  task automatic write_reg(input logic [jetp_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [jetp_pkg::COORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    book.write_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_view(input int xs, input int ys, input int xd, input int yd,
                            input int cr, input int ci, input int limit);
    write_reg(jetp_pkg::REG_X_START,  xs);
    write_reg(jetp_pkg::REG_Y_START,  ys);
    write_reg(jetp_pkg::REG_X_STEP,   xd);
    write_reg(jetp_pkg::REG_Y_STEP,   yd);
    write_reg(jetp_pkg::REG_C_REAL,   cr);
    write_reg(jetp_pkg::REG_C_IMAG,   ci);
    write_reg(jetp_pkg::REG_MAX_ITER, limit);
    views++;
  endtask

  // Offers one pixel word, optionally after a gap, and holds it until the
  // block takes it. Entered and left on a falling edge; tvalid stays high on
  // return so the next word can follow without a bubble.
  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= PIX_W'({row, col});
    do @(posedge clk); while (!s_tready);
    book.take_pixel(col, row);
    @(negedge clk);
  endtask

  // Stops offering words and waits until every outstanding result is back,
  // then lets the block settle. Words that never show up count as errors.
  task automatic drain();
    int waited;
    s_tvalid <= 1'b0;
    waited = 0;
    while (book.outstanding() > 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (book.outstanding() > 0) begin
      $display("%0t: %0d result words never arrived", $time, book.outstanding());
      book.errors += book.outstanding();
      book.awaited.delete();
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  // A view around the Julia set: start near -2 or +2, steps so that the
  // full index range spans a few units, c within the unit square, and a
  // small limit so that inner points stay cheap. Wild views use raw
  // register values.
  task automatic random_view(input bit wild);
    int xs, ys, xd, yd, cr, ci;
    if (wild) begin
      write_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(1, 1000));
    end else begin
      xs = -134217728 + int'($urandom_range(0, 1 << 24)) - (1 << 23);
      ys = -134217728 + int'($urandom_range(0, 1 << 24)) - (1 << 23);
      xd = $urandom_range(16384, 65536);
      yd = $urandom_range(16384, 65536);
      if ($urandom_range(0, 1)) begin
        xs = -xs;
        xd = -xd;
      end
      if ($urandom_range(0, 1)) begin
        ys = -ys;
        yd = -yd;
      end
      cr = int'($urandom_range(0, 1 << 27)) - (1 << 26);
      ci = int'($urandom_range(0, 1 << 27)) - (1 << 26);
      write_view(xs, ys, xd, yd, cr, ci, $urandom_range(1, 400));
    end
  endtask

  initial begin : stimulus
    int ph;
    int n;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset view: image corners, alternating index bits, and the pixel that
    // lands on the origin, which stays bounded up to the default limit.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd400, 12'd200);
    send_pixel(12'haaa, 12'h555);
    send_pixel(12'h555, 12'haaa);
    drain();

    // Every register at an extreme. The origin pixel sits far outside the
    // bailout circle; any other index pushes a start coordinate past the
    // 32-bit range. A write to the unused index must change nothing.
    steady = 1'b1;
    write_reg(REG_SPARE, 32'h1234_5678);
    write_view(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'h8000_0000, 32'h7fff_ffff, 65535);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    drain();
    steady = 1'b0;

    // z starts at 1.9 and c is pushed to the top of the range, so the first
    // update saturates; with a limit of one it also reaches the limit.
    write_view(127506842, 0, 1 << 20, 1 << 20, 32'h7fff_ffff, 0, 1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd3, 12'd7);
    send_pixel(12'd64, 12'd0);
    drain();

    // A zero limit reports nothing done, unless the start already saturates.
    write_reg(jetp_pkg::REG_MAX_ITER, 0);
    views++;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // c = 0 with a 1/64 grid: the origin never moves and runs to the widest
    // limit, a point at exactly radius two sits on the bailout boundary and
    // is still inside, and the far corner overflows its start.
    write_view(0, 0, 1 << 20, 1 << 20, 0, 0, 65535);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd100, 12'd0);
    send_pixel(12'd0, 12'd128);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // Random pixels over several random views, one of them with raw register
    // values and one with no gaps at all. Partway into the first view the
    // sender holds off until the block has handed back everything.
    for (ph = 0; ph < 4; ph++) begin
      steady = (ph == 1);
      random_view(ph == 2);
      for (n = 0; n < 25; n++) begin
        if (ph == 0 && n == 12) drain();
        send_pixel(COL_W'($urandom_range(0, MAX_COLUMNS - 1)),
                   ROW_W'($urandom_range(0, MAX_ROWS - 1)));
      end
      drain();
    end
    steady = 1'b0;

    $display("julia_escape_time_pixel_tb: %0d pixel words checked over %0d register views,",
             book.checked, views);
    $display("julia_escape_time_pixel_tb: longest pixel ran %0d iterations", book.deepest);
    if (book.errors == 0) begin
      $display("julia_escape_time_pixel_tb: done, clean");
    end else begin
      $display("julia_escape_time_pixel_tb: done, errors");
    end
    $finish;
  end

  // The slowest correct run stays well inside this bound; past it the bench
  // gives up and reports errors.
  initial begin : watchdog
    #100_000_000;
    $display("julia_escape_time_pixel_tb: done, errors");
    $finish;
  end

endmodule
